@@ rtl/stc_pkg.sv @@
// Package for the step sequencer transport: command codes, controller states
// and fixed field widths. No dependencies; used by stc_div and the top level.
`timescale 1ns / 1ps

package stc_pkg;

    localparam int FIELD_W = 11;
    localparam int PAT_W   = 6;
    localparam int CALC_W  = 24;

    localparam logic [PAT_W-1:0] PATTERN_TOP = 6'd63;

    typedef logic [3:0] func_t;

    localparam func_t FN_STEP          = 4'd0;
    localparam func_t FN_SET_PATTERN   = 4'd1;
    localparam func_t FN_ADD_PATTERN   = 4'd2;
    localparam func_t FN_SET_MEASURE   = 4'd3;
    localparam func_t FN_SET_STEP_IN_M = 4'd4;
    localparam func_t FN_SET_STEP      = 4'd5;
    localparam func_t FN_LOCK          = 4'd6;
    localparam func_t FN_UNLOCK        = 4'd7;
    localparam func_t FN_TOGGLE_RUN    = 4'd8;
    localparam func_t FN_SET_RUN       = 4'd9;
    localparam func_t FN_TOGGLE_RECORD = 4'd10;
    localparam func_t FN_REWIND        = 4'd11;
    localparam func_t FN_TAKE_DIRTY    = 4'd12;
    localparam func_t FN_QUERY         = 4'd13;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN1,
        ST_WAIT1,
        ST_APPLY,
        ST_RUN2,
        ST_WAIT2,
        ST_OUT
    } state_t;

endpackage

@@ rtl/stc_div.sv @@
// Bit-serial restoring divider with C truncating sign rules, one quotient bit
// per cycle. Depends on stc_pkg for the divisor width.
`timescale 1ns / 1ps

module stc_div #(
    parameter int DW = 11
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [DW:0]                dividend,
    input  logic [stc_pkg::FIELD_W-1:0]       divisor,
    output logic                              done,
    output logic signed [DW:0]                quot,
    output logic signed [stc_pkg::FIELD_W:0]  rem
);

    localparam int RW    = stc_pkg::FIELD_W;
    localparam int CNT_W = $clog2(DW);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             neg_reg;
    logic [DW-1:0]    dq_reg;
    logic [RW-1:0]    rem_reg;
    logic [RW-1:0]    dvs_reg;

    logic signed [DW:0] neg_dividend;
    logic [DW-1:0]      mag;
    logic [RW:0]        part;
    logic [RW:0]        diff;
    logic               fits;
    logic signed [DW:0] qpos;
    logic signed [RW:0] rpos;

    assign neg_dividend = -dividend;
    assign mag  = dividend[DW] ? neg_dividend[DW-1:0] : dividend[DW-1:0];
    assign part = {rem_reg, dq_reg[DW-1]};
    assign fits = (part >= {1'b0, dvs_reg});
    assign diff = part - {1'b0, dvs_reg};
    assign qpos = {1'b0, dq_reg};
    assign rpos = {1'b0, rem_reg};
    assign quot = neg_reg ? -qpos : qpos;
    assign rem  = neg_reg ? -rpos : rpos;
    assign done = done_reg;

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DW - 1);
        end else if (busy_reg) begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= dividend[DW];
            dq_reg  <= mag;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[RW-1:0] : part[RW-1:0];
            dq_reg  <= {dq_reg[DW-2:0], fits};
        end
    end

endmodule

@@ rtl/sequencer_transport_control.sv @@
// Top level of the step sequencer transport: request decode, transport state
// and result register. Depends on stc_pkg and two stc_div lanes.
`timescale 1ns / 1ps

// Each request is handled in two passes of the DW-bit dividers, where DW is
// the larger of 11 and clog2(MAX_STEPS)+1: the first pass divides the old step
// and the wrap or argument term, the second divides the new step for the
// measure and step-in-measure results. A new request is accepted only after
// the previous one has been loaded into the result register. The result
// register lets the next request be taken while a finished result still
// waits on m_tready.

module sequencer_transport_control #(
    parameter int MAX_STEPS = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // func[3:0], value[14:4], steps_per_measure[25:15], steps_in_pattern[36:26]
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // pattern_now[5:0], step_now[16:6], measure_now[26:17],
    // step_in_measure_now[37:27], run_flag[38], lock_flag[39],
    // record_flag[40], armed_flag[41], changed_flag[42]
    output logic [47:0] m_tdata,
    output logic        m_tlast
);

    localparam int SW = $clog2(MAX_STEPS) + 1;
    localparam int DW = (SW > stc_pkg::FIELD_W) ? SW : stc_pkg::FIELD_W;
    localparam int CW = stc_pkg::CALC_W;
    localparam int FW = stc_pkg::FIELD_W;
    localparam int PW = stc_pkg::PAT_W;

    localparam logic signed [CW-1:0] STEP_TOP    = CW'(MAX_STEPS - 1);
    localparam logic signed [CW-1:0] STEP_NONE_W = '1;
    localparam logic signed [SW-1:0] STEP_NONE   = '1;

    stc_pkg::state_t state_reg, state_next;

    stc_pkg::func_t    func_reg;
    logic signed [FW-1:0] val_reg;
    logic [FW-1:0]     spm_reg;
    logic [FW-1:0]     sip_reg;
    logic signed [CW-1:0] prod_reg;

    logic [PW-1:0]        pattern_reg, pattern_next;
    logic signed [SW-1:0] step_reg, step_next;
    logic running_reg, running_next;
    logic locked_reg, locked_next;
    logic recording_reg, recording_next;
    logic armed_reg, armed_next;
    logic dirty_reg, dirty_next;
    logic changed_reg, changed_next;

    logic        m_valid_reg, m_valid_next;
    logic [47:0] m_data_reg, m_data_next;
    logic        m_last_reg, m_last_next;

    logic signed [CW-1:0] step_w, step_inc_w, val_w, spm_w, sip_w;
    logic signed [CW-1:0] ra_w, rb_w, first_w;
    logic signed [CW-1:0] ns_w, fst_w, sat_w, last_w, pat_w;
    logic [PW-1:0]        pat_clamp;

    logic                 start_a, start_b, done_a, done_b;
    logic signed [DW:0]   dividend_b;
    logic [FW-1:0]        divisor_b;
    logic signed [DW:0]   quot_a, quot_b;
    logic signed [FW:0]   rem_a, rem_b;
    logic                 s_accept;

    function automatic logic signed [CW-1:0] sat_step(input logic signed [CW-1:0] s);
        logic signed [CW-1:0] r;
        r = s;
        if (s < STEP_NONE_W) begin
            r = STEP_NONE_W;
        end else if (s > STEP_TOP) begin
            r = STEP_TOP;
        end
        return r;
    endfunction

    function automatic logic [PW-1:0] clamp_pat(input logic signed [CW-1:0] p);
        logic [PW-1:0] r;
        r = p[PW-1:0];
        if (p < 0) begin
            r = '0;
        end else if (p > CW'(stc_pkg::PATTERN_TOP)) begin
            r = stc_pkg::PATTERN_TOP;
        end
        return r;
    endfunction

    assign s_accept   = s_tvalid && s_tready;
    assign s_tready   = (state_reg == stc_pkg::ST_IDLE);
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tlast    = m_last_reg;

    assign step_w     = {{(CW-SW){step_reg[SW-1]}}, step_reg};
    assign step_inc_w = step_w + 1'b1;
    assign val_w      = {{(CW-FW){val_reg[FW-1]}}, val_reg};
    assign spm_w      = {{(CW-FW){1'b0}}, spm_reg};
    assign sip_w      = {{(CW-FW){1'b0}}, sip_reg};
    assign ra_w       = {{(CW-FW-1){rem_a[FW]}}, rem_a};
    assign rb_w       = {{(CW-FW-1){rem_b[FW]}}, rem_b};
    assign first_w    = step_w - ra_w;

    assign start_a    = (state_reg == stc_pkg::ST_RUN1) || (state_reg == stc_pkg::ST_RUN2);
    assign start_b    = (state_reg == stc_pkg::ST_RUN1);
    assign dividend_b = (func_reg == stc_pkg::FN_STEP) ? step_inc_w[DW:0] : val_w[DW:0];
    assign divisor_b  = (func_reg == stc_pkg::FN_STEP) ? sip_reg : spm_reg;

    stc_div #(.DW(DW)) u_div_a (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start_a),
        .dividend (step_w[DW:0]),
        .divisor  (spm_reg),
        .done     (done_a),
        .quot     (quot_a),
        .rem      (rem_a)
    );

    stc_div #(.DW(DW)) u_div_b (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start_b),
        .dividend (dividend_b),
        .divisor  (divisor_b),
        .done     (done_b),
        .quot     (quot_b),
        .rem      (rem_b)
    );

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            func_reg <= s_tdata[3:0];
            val_reg  <= s_tdata[14:4];
            spm_reg  <= (s_tdata[25:15] == '0) ? FW'(1) : s_tdata[25:15];
            sip_reg  <= (s_tdata[36:26] == '0) ? FW'(1) : s_tdata[36:26];
        end
        prod_reg   <= spm_w * val_w;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= stc_pkg::ST_IDLE;
            pattern_reg   <= '0;
            step_reg      <= STEP_NONE;
            running_reg   <= 1'b1;
            locked_reg    <= 1'b0;
            recording_reg <= 1'b0;
            armed_reg     <= 1'b0;
            dirty_reg     <= 1'b1;
            changed_reg   <= 1'b1;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pattern_reg   <= pattern_next;
            step_reg      <= step_next;
            running_reg   <= running_next;
            locked_reg    <= locked_next;
            recording_reg <= recording_next;
            armed_reg     <= armed_next;
            dirty_reg     <= dirty_next;
            changed_reg   <= changed_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        pattern_next   = pattern_reg;
        step_next      = step_reg;
        running_next   = running_reg;
        locked_next    = locked_reg;
        recording_next = recording_reg;
        armed_next     = armed_reg;
        dirty_next     = dirty_reg;
        changed_next   = changed_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        m_last_next    = m_last_reg;
        ns_w           = rb_w;
        fst_w          = '0;
        sat_w          = '0;
        last_w         = prod_reg + spm_w - 1'b1;
        pat_w          = (func_reg == stc_pkg::FN_ADD_PATTERN)
                         ? ({{(CW-PW){1'b0}}, pattern_reg} + val_w) : val_w;
        pat_clamp      = clamp_pat(pat_w);

        unique case (state_reg)
            stc_pkg::ST_IDLE: begin
                if (s_accept) begin
                    state_next = stc_pkg::ST_RUN1;
                end
            end
            stc_pkg::ST_RUN1: begin
                state_next = stc_pkg::ST_WAIT1;
            end
            stc_pkg::ST_WAIT1: begin
                if (done_a && done_b) begin
                    state_next = stc_pkg::ST_APPLY;
                end
            end
            stc_pkg::ST_APPLY: begin
                state_next = stc_pkg::ST_RUN2;
                unique case (func_reg) inside
                    stc_pkg::FN_STEP: begin
                        if (running_reg) begin
                            dirty_next = 1'b1;
                            if (locked_reg) begin
                                fst_w = first_w;
                                if (!(rb_w >= first_w && rb_w < first_w + spm_w)) begin
                                    ns_w = first_w;
                                end
                            end
                            sat_w     = sat_step(ns_w);
                            step_next = sat_w[SW-1:0];
                            if (sat_w == fst_w) begin
                                if (recording_reg) begin
                                    armed_next     = 1'b0;
                                    recording_next = 1'b0;
                                end else if (armed_reg) begin
                                    armed_next     = 1'b0;
                                    recording_next = 1'b1;
                                end
                            end
                        end
                    end
                    stc_pkg::FN_SET_PATTERN, stc_pkg::FN_ADD_PATTERN: begin
                        if (func_reg == stc_pkg::FN_ADD_PATTERN && val_reg != '0) begin
                            dirty_next = 1'b1;
                        end
                        if (pat_clamp != pattern_reg) begin
                            dirty_next   = 1'b1;
                            pattern_next = pat_clamp;
                            step_next    = STEP_NONE;
                        end
                    end
                    stc_pkg::FN_SET_MEASURE: begin
                        if (step_w < prod_reg || step_w > last_w) begin
                            dirty_next = 1'b1;
                            sat_w      = sat_step(last_w);
                            step_next  = sat_w[SW-1:0];
                        end
                    end
                    stc_pkg::FN_SET_STEP_IN_M, stc_pkg::FN_SET_STEP: begin
                        if (func_reg == stc_pkg::FN_SET_STEP) begin
                            sat_w = sat_step(val_w);
                        end else begin
                            sat_w = sat_step(first_w + rb_w);
                        end
                        if (sat_w != step_w) begin
                            dirty_next = 1'b1;
                        end
                        step_next = sat_w[SW-1:0];
                    end
                    stc_pkg::FN_LOCK: begin
                        if (!locked_reg) begin
                            dirty_next = 1'b1;
                        end
                        locked_next = 1'b1;
                    end
                    stc_pkg::FN_UNLOCK: begin
                        if (locked_reg) begin
                            dirty_next = 1'b1;
                        end
                        locked_next = 1'b0;
                    end
                    stc_pkg::FN_TOGGLE_RUN: begin
                        dirty_next   = 1'b1;
                        running_next = !running_reg;
                    end
                    stc_pkg::FN_SET_RUN: begin
                        if (running_reg != (val_reg != '0)) begin
                            dirty_next = 1'b1;
                        end
                        running_next = (val_reg != '0);
                    end
                    stc_pkg::FN_TOGGLE_RECORD: begin
                        dirty_next = 1'b1;
                        if (!recording_reg) begin
                            armed_next = !armed_reg;
                        end else begin
                            recording_next = 1'b0;
                            armed_next     = 1'b0;
                        end
                    end
                    stc_pkg::FN_REWIND: begin
                        dirty_next = 1'b1;
                        step_next  = STEP_NONE;
                    end
                    stc_pkg::FN_TAKE_DIRTY: begin
                        dirty_next = 1'b0;
                    end
                    default: begin
                    end
                endcase
                changed_next = (func_reg == stc_pkg::FN_TAKE_DIRTY) ? dirty_reg : dirty_next;
            end
            stc_pkg::ST_RUN2: begin
                state_next = stc_pkg::ST_WAIT2;
            end
            stc_pkg::ST_WAIT2: begin
                if (done_a) begin
                    state_next = stc_pkg::ST_OUT;
                end
            end
            stc_pkg::ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {5'b0, changed_reg, armed_reg, recording_reg,
                                    locked_reg, running_reg, rem_a[FW-1:0],
                                    quot_a[9:0], step_w[FW-1:0], pattern_reg};
                    m_last_next  = (step_w == sip_w - 1'b1);
                    state_next   = stc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = stc_pkg::ST_IDLE;
            end
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        !(recording_reg && armed_reg))
        else $error("recording and armed set together");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (step_w >= STEP_NONE_W) && (step_w <= STEP_TOP))
        else $error("step position out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == stc_pkg::ST_RUN1))
        else $error("accepted request did not start the divider pass");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == stc_pkg::ST_OUT && (!m_valid_reg || m_tready))
        |=> (m_valid_reg && state_reg == stc_pkg::ST_IDLE))
        else $error("result was not loaded into the output register");

endmodule

@@ dv/tb_sequencer_transport_control.sv @@
// Self-checking testbench for the step sequencer transport. It drives command
// requests and compares each result with a transport model kept in this file.
// Depends on stc_pkg and sequencer_transport_control.
`timescale 1ns / 1ps

module tb_sequencer_transport_control;

    localparam int STEP_LIMIT  = 1024;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT    = 36;

    typedef struct {
        logic [5:0]  pattern;
        logic [10:0] step;
        logic [9:0]  measure;
        logic [10:0] step_in_measure;
        logic        last;
        logic        run;
        logic        lock;
        logic        rec;
        logic        arm;
        logic        changed;
    } transport_view_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tlast;

    transport_view_t pending_views[$];
    int error_count = 0;
    int cycle_count = 0;
    int hold_left   = 0;
    bit steady_flow = 1'b0;

    int cur_pattern;
    int cur_step;
    bit is_running;
    bit is_locked;
    bit is_recording;
    bit is_armed;
    bit dirty_mark;

    sequencer_transport_control #(
        .MAX_STEPS(STEP_LIMIT)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic int clip_step(input int s);
        if (s < -1) return -1;
        if (s > STEP_LIMIT - 1) return STEP_LIMIT - 1;
        return s;
    endfunction

    function automatic void place_pattern(input int p);
        if (p < 0) p = 0;
        if (p > int'(stc_pkg::PATTERN_TOP)) p = int'(stc_pkg::PATTERN_TOP);
        if (p != cur_pattern) begin
            dirty_mark  = 1'b1;
            cur_pattern = p;
            cur_step    = -1;
        end
    endfunction

    function automatic transport_view_t advance_transport(input logic [39:0] word);
        stc_pkg::func_t fn;
        int val, spm, sip, ns, first, m0, m1;
        bit prior, took;
        transport_view_t v;
        fn    = word[3:0];
        val   = $signed(word[14:4]);
        spm   = word[25:15];
        sip   = word[36:26];
        took  = 1'b0;
        prior = dirty_mark;
        if (spm == 0) spm = 1;
        if (sip == 0) sip = 1;
        case (fn)
            stc_pkg::FN_STEP: begin
                if (is_running) begin
                    first      = 0;
                    m0         = cur_step / spm;
                    dirty_mark = 1'b1;
                    ns         = (cur_step + 1) % sip;
                    m1         = ns / spm;
                    if (is_locked) begin
                        first = m0 * spm;
                        if (m0 != m1) ns = first;
                    end
                    cur_step = clip_step(ns);
                    if (is_recording && cur_step == first) begin
                        is_armed     = 1'b0;
                        is_recording = 1'b0;
                    end
                    if (is_armed && cur_step == first) begin
                        is_armed     = 1'b0;
                        is_recording = 1'b1;
                    end
                end
            end
            stc_pkg::FN_SET_PATTERN: place_pattern(val);
            stc_pkg::FN_ADD_PATTERN: begin
                if (val != 0) dirty_mark = 1'b1;
                place_pattern(cur_pattern + val);
            end
            stc_pkg::FN_SET_MEASURE: begin
                first = spm * val;
                m1    = first + spm - 1;
                if (cur_step < first || cur_step > m1) begin
                    dirty_mark = 1'b1;
                    cur_step   = clip_step(m1);
                end
            end
            stc_pkg::FN_SET_STEP_IN_M: begin
                ns = clip_step((cur_step / spm) * spm + (val % spm));
                if (ns != cur_step) dirty_mark = 1'b1;
                cur_step = ns;
            end
            stc_pkg::FN_SET_STEP: begin
                ns = clip_step(val);
                if (ns != cur_step) dirty_mark = 1'b1;
                cur_step = ns;
            end
            stc_pkg::FN_LOCK: begin
                if (!is_locked) dirty_mark = 1'b1;
                is_locked = 1'b1;
            end
            stc_pkg::FN_UNLOCK: begin
                if (is_locked) dirty_mark = 1'b1;
                is_locked = 1'b0;
            end
            stc_pkg::FN_TOGGLE_RUN: begin
                dirty_mark = 1'b1;
                is_running = !is_running;
            end
            stc_pkg::FN_SET_RUN: begin
                if (is_running != (val != 0)) dirty_mark = 1'b1;
                is_running = (val != 0);
            end
            stc_pkg::FN_TOGGLE_RECORD: begin
                dirty_mark = 1'b1;
                if (!is_recording) begin
                    is_armed = !is_armed;
                end else begin
                    is_recording = 1'b0;
                    is_armed     = 1'b0;
                end
            end
            stc_pkg::FN_REWIND: begin
                dirty_mark = 1'b1;
                cur_step   = -1;
            end
            stc_pkg::FN_TAKE_DIRTY: begin
                took       = 1'b1;
                dirty_mark = 1'b0;
            end
            default: ;
        endcase
        v.pattern         = 6'(cur_pattern);
        v.step            = 11'(cur_step);
        v.measure         = 10'(cur_step / spm);
        v.step_in_measure = 11'(cur_step % spm);
        v.last            = (cur_step == sip - 1);
        v.run             = is_running;
        v.lock            = is_locked;
        v.rec             = is_recording;
        v.arm             = is_armed;
        v.changed         = took ? prior : dirty_mark;
        return v;
    endfunction

    task automatic flag_error(input string msg);
        if (error_count < 40) $display("ERROR at %0t ns: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want) flag_error($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task automatic check_result(input logic [47:0] word, input logic last);
        transport_view_t want;
        if (pending_views.size() == 0) begin
            flag_error("result arrived with no request pending");
            return;
        end
        want = pending_views.pop_front();
        compare_field("pattern_now", word[5:0], want.pattern);
        compare_field("step_now", word[16:6], want.step);
        compare_field("measure_now", word[26:17], want.measure);
        compare_field("step_in_measure_now", word[37:27], want.step_in_measure);
        compare_field("last_step", last, want.last);
        compare_field("run_flag", word[38], want.run);
        compare_field("lock_flag", word[39], want.lock);
        compare_field("record_flag", word[40], want.rec);
        compare_field("armed_flag", word[41], want.arm);
        compare_field("changed_flag", word[42], want.changed);
    endtask

    task automatic send_request(input stc_pkg::func_t fn, input int arg, input int spm,
                                input int sip);
        logic [39:0] word;
        word = {3'b000, 11'(sip), 11'(spm), 11'(arg), fn};
        while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        pending_views.push_back(advance_transport(word));
    endtask

    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) check_result(m_tdata, m_tlast);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        while (cycle_count <= CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    task automatic test_directed();
        send_request(stc_pkg::FN_QUERY, 0, 4, 16);
        send_request(stc_pkg::FN_TAKE_DIRTY, 0, 4, 16);
        send_request(stc_pkg::FN_TAKE_DIRTY, 0, 4, 16);
        send_request(stc_pkg::FN_STEP, 0, 4, 16);
        send_request(stc_pkg::FN_SET_STEP, 15, 4, 16);
        send_request(stc_pkg::FN_STEP, 0, 4, 16);
        send_request(stc_pkg::FN_SET_PATTERN, -1024, 4, 16);
        send_request(stc_pkg::FN_SET_PATTERN, 1023, 4, 16);
        send_request(stc_pkg::FN_ADD_PATTERN, -1024, 4, 16);
        send_request(stc_pkg::FN_ADD_PATTERN, 0, 4, 16);
        send_request(stc_pkg::FN_SET_MEASURE, 3, 4, 16);
        send_request(stc_pkg::FN_SET_MEASURE, -1024, 1024, 1024);
        send_request(stc_pkg::FN_SET_MEASURE, 1023, 1024, 1024);
        send_request(stc_pkg::FN_STEP, 0, 1024, 2047);
        send_request(stc_pkg::FN_SET_STEP, -1024, 4, 16);
        send_request(stc_pkg::FN_SET_STEP, 1023, 4, 16);
        send_request(stc_pkg::FN_SET_STEP_IN_M, -3, 7, 16);
        send_request(stc_pkg::FN_SET_STEP, 6, 4, 16);
        send_request(stc_pkg::FN_LOCK, 0, 4, 16);
        send_request(stc_pkg::FN_TOGGLE_RECORD, 0, 4, 16);
        // Locked to the second measure, recording starts when the loop wraps.
        repeat (4) send_request(stc_pkg::FN_STEP, 0, 4, 16);
        send_request(stc_pkg::FN_TOGGLE_RECORD, 0, 4, 16);
        send_request(stc_pkg::FN_UNLOCK, 0, 4, 16);
        send_request(stc_pkg::FN_TOGGLE_RUN, 0, 4, 16);
        send_request(stc_pkg::FN_STEP, 0, 4, 16);
        send_request(stc_pkg::FN_SET_RUN, 0, 4, 16);
        send_request(stc_pkg::FN_SET_RUN, -1, 4, 16);
        send_request(stc_pkg::FN_REWIND, 0, 4, 16);
        send_request(stc_pkg::func_t'(14), 1023, 2047, 2047);
        send_request(stc_pkg::func_t'(15), -1024, 0, 0);
        send_request(stc_pkg::FN_STEP, 0, 0, 0);
    endtask

    task automatic test_random_traffic(input int count);
        int spm, sip, item_spm, item_sip, arg, pick;
        stc_pkg::func_t fn;
        spm = 4;
        sip = 16;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 5) begin
                spm = $urandom_range(1, 8);
                sip = spm * $urandom_range(1, 6);
            end
            if (pick < 50) begin
                fn = stc_pkg::FN_STEP;
            end else if (pick < 92) begin
                fn = stc_pkg::func_t'($urandom_range(stc_pkg::FN_SET_PATTERN,
                                                     stc_pkg::FN_QUERY));
            end else begin
                fn = stc_pkg::func_t'($urandom_range(15));
            end
            if ($urandom_range(9) < 7) arg = $urandom_range(0, sip + 1) - 1;
            else arg = $urandom_range(2047) - 1024;
            item_spm = spm;
            item_sip = sip;
            if ($urandom_range(49) == 0) begin
                item_spm = $urandom_range(2047);
                item_sip = $urandom_range(2047);
            end
            send_request(fn, arg, item_spm, item_sip);
        end
    endtask

    task automatic test_steady_burst(input int count);
        steady_flow = 1'b1;
        test_random_traffic(count);
        steady_flow = 1'b0;
    endtask

    task automatic test_backpressure();
        steady_flow = 1'b1;
        hold_left   = 400;
        for (int i = 0; i < 16; i++) begin
            send_request(i[0] ? stc_pkg::FN_STEP : stc_pkg::FN_QUERY, i, 3, 12);
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        aresetn <= 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        cur_pattern  = 0;
        cur_step     = -1;
        is_running   = 1'b1;
        is_locked    = 1'b0;
        is_recording = 1'b0;
        is_armed     = 1'b0;
        dirty_mark   = 1'b1;

        test_directed();
        test_random_traffic(700);
        test_steady_burst(120);
        test_backpressure();
        test_random_traffic(60);
        s_tvalid <= 1'b0;

        while (pending_views.size() != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
